### hw/rtl/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types and constants for the posit (es=0) / binary64 converter.
// ----------------------------------------------------------------------------
package pdc_pkg;

    typedef enum logic [1:0] {
        MODE_D2P16 = 2'd0,
        MODE_D2P8  = 2'd1,
        MODE_P2D   = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    localparam logic [63:0] DBL_POS_INF  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] DBL_SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam logic [10:0] DBL_EXP_BIAS = 11'd1023;

    localparam logic [15:0] P16_NAR = 16'h8000;
    localparam logic [7:0]  P8_NAR  = 8'h80;

    localparam logic signed [5:0] P16_EMAX = 6'sd14;
    localparam logic signed [5:0] P16_EMIN = -6'sd15;
    localparam logic signed [5:0] P8_EMAX  = 6'sd6;
    localparam logic signed [5:0] P8_EMIN  = -6'sd7;

    // Exponent bases and fraction shift offset used when rebuilding a double from the regime run
    localparam logic [10:0] P2D_EXP_SHORT = 11'd1024;
    localparam logic [10:0] P2D_EXP_LONG  = 11'd1021;
    localparam logic [5:0]  P2D_FRAC_OFS  = 6'd37;

endpackage

### hw/rtl/posit_double_converter_core.sv
// ----------------------------------------------------------------------------
// posit_double_converter_core
// Converts binary64 to posit16 or posit8 (es=0), and posit16 to binary64.
// An item passes from the input register through the conversion logic into
// the result register. A new item is taken every cycle unless in_stall is
// high; the result register and the input register form a two-entry pipeline,
// so input stalls only when both hold an item and the result side stalls.
// Posit results sit zero-extended in the low bits of result_bits; an unused
// mode code gives zero.
// ----------------------------------------------------------------------------
module posit_double_converter_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              mode,
    input  logic [63:0]             double_bits,
    input  logic [15:0]             posit_bits,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [63:0]             result_bits
);
    import pdc_pkg::*;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    mode_t         s1_mode_reg;
    mode_t         s1_mode_next;
    logic [63:0]   s1_dbl_reg;
    logic [63:0]   s1_dbl_next;
    logic [15:0]   s1_pos_reg;
    logic [15:0]   s1_pos_next;
    logic          s2_valid_reg;
    logic          s2_valid_next;
    logic [63:0]   s2_result_reg;
    logic [63:0]   s2_result_next;

    logic          s2_load;
    logic          in_xfer;
    logic [63:0]   d2p_result;
    logic [63:0]   p2d_result;
    logic [63:0]   conv_result;

    pdc_dbl2pos u_dbl2pos (
        .double_bits (s1_dbl_reg),
        .is_p8       (s1_mode_reg == MODE_D2P8),
        .result_bits (d2p_result)
    );

    pdc_pos2dbl u_pos2dbl (
        .posit_bits  (s1_pos_reg),
        .result_bits (p2d_result)
    );

    always_comb
    begin
        case (s1_mode_reg)
            MODE_D2P16: conv_result = d2p_result;
            MODE_D2P8:  conv_result = d2p_result;
            MODE_P2D:   conv_result = p2d_result;
            default:    conv_result = 64'd0;
        endcase
    end

    assign s2_load  = !s2_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s2_load;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_mode_next   = s1_mode_reg;
        s1_dbl_next    = s1_dbl_reg;
        s1_pos_next    = s1_pos_reg;
        s2_valid_next  = s2_valid_reg;
        s2_result_next = s2_result_reg;

        // advance the input stage whenever it is not held
        if (!in_stall)
        begin
            s1_valid_next = in_valid;
        end
        if (in_xfer)
        begin
            s1_mode_next = mode_t'(mode);
            s1_dbl_next  = double_bits;
            s1_pos_next  = posit_bits;
        end
        if (s2_load)
        begin
            s2_valid_next  = s1_valid_reg;
            s2_result_next = conv_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mode_reg   <= s1_mode_next;
        s1_dbl_reg    <= s1_dbl_next;
        s1_pos_reg    <= s1_pos_next;
        s2_result_reg <= s2_result_next;
    end

    assign out_valid   = s2_valid_reg;
    assign result_bits = s2_result_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && out_stall))
        else $error("input stalled while pipeline has room");

    a_in_xfer_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> s1_valid_reg)
        else $error("transfer lost at input stage");

    a_s1_moves_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_load) |=> out_valid)
        else $error("item lost between stages");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(result_bits)))
        else $error("stalled result changed");

endmodule

### hw/rtl/pdc_dbl2pos.sv
// ----------------------------------------------------------------------------
// pdc_dbl2pos
// Binary64 to posit16 or posit8 (es=0), round to nearest even. Combinational.
// ----------------------------------------------------------------------------
module pdc_dbl2pos (
    input  logic [63:0]   double_bits,
    input  logic          is_p8,
    output logic [63:0]   result_bits
);
    import pdc_pkg::*;

    logic                 neg;
    logic                 is_zero;
    logic                 is_pinf;
    logic signed [12:0]   e_full;
    logic signed [5:0]    e_max;
    logic signed [5:0]    e_min;
    logic signed [5:0]    e_clamp;
    logic signed [5:0]    e_neg;
    logic                 e_nonneg;
    logic [3:0]           sh;
    logic [63:0]          w_pre;
    logic [63:0]          w;
    logic                 rnd16;
    logic                 rnd8;
    logic [15:0]          mag16;
    logic [7:0]           mag8;
    logic [15:0]          p16;
    logic [7:0]           p8;

    always_comb
    begin
        neg     = double_bits[63];
        is_zero = (double_bits[62:0] == 63'd0);
        is_pinf = (double_bits == DBL_POS_INF);

        e_full = $signed({2'b00, double_bits[62:52]}) - $signed({2'b00, DBL_EXP_BIAS});
        e_max  = is_p8 ? P8_EMAX : P16_EMAX;
        e_min  = is_p8 ? P8_EMIN : P16_EMIN;
        if (e_full > 13'(e_max))
        begin
            e_clamp = e_max;
        end
        else if (e_full < 13'(e_min))
        begin
            e_clamp = e_min;
        end
        else
        begin
            e_clamp = e_full[5:0];
        end

        e_nonneg = !e_clamp[5];
        e_neg    = -e_clamp;
        sh       = e_nonneg ? (e_clamp[3:0] + 4'd1) : e_neg[3:0];

        // top bit equals fill bit, so one arithmetic shift builds the regime
        w_pre = {e_nonneg, !e_nonneg, double_bits[51:0], 10'd0};
        w     = 64'($signed(w_pre) >>> sh);

        rnd16 = w[47] && (w[48] || (|w[46:0]));
        rnd8  = w[55] && (w[56] || (|w[54:0]));
        mag16 = {1'b0, w[62:48]} + {15'd0, rnd16};
        mag8  = {1'b0, w[62:56]} + {7'd0, rnd8};

        if (is_pinf)
        begin
            p16 = P16_NAR;
            p8  = P8_NAR;
        end
        else if (is_zero)
        begin
            p16 = 16'd0;
            p8  = 8'd0;
        end
        else
        begin
            p16 = neg ? (16'd0 - mag16) : mag16;
            p8  = neg ? (8'd0 - mag8) : mag8;
        end

        result_bits = is_p8 ? {56'd0, p8} : {48'd0, p16};
    end

endmodule

### hw/rtl/pdc_pos2dbl.sv
// ----------------------------------------------------------------------------
// pdc_pos2dbl
// Posit16 (es=0) to binary64; regime run found by leading-zero count.
// ----------------------------------------------------------------------------
module pdc_pos2dbl (
    input  logic [15:0]   posit_bits,
    output logic [63:0]   result_bits
);
    import pdc_pkg::*;

    function automatic logic [4:0] clz16(input logic [15:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd16;
        found = 1'b0;
        for (int i = 15; i >= 0; i--)
        begin
            if (!found && v[i])
            begin
                n     = 5'(15 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    logic          neg;
    logic [15:0]   pp;
    logic [15:0]   z;
    logic [4:0]    run;
    logic [10:0]   exponent;
    logic [5:0]    sh;
    logic [63:0]   frac_wide;

    always_comb
    begin
        neg = posit_bits[15];
        pp  = neg ? (16'd0 - posit_bits) : posit_bits;
        z   = {1'b0, ~pp[14:0]};

        if (!pp[14])
        begin
            run      = clz16(pp);
            exponent = P2D_EXP_SHORT - {6'd0, run};
        end
        else
        begin
            run      = clz16(z);
            exponent = P2D_EXP_LONG + {6'd0, run};
        end

        sh        = {1'b0, run} + P2D_FRAC_OFS;
        frac_wide = {48'd0, pp} << sh;

        if (posit_bits == P16_NAR)
        begin
            result_bits = DBL_POS_INF;
        end
        else if (posit_bits == 16'd0)
        begin
            result_bits = 64'd0;
        end
        else
        begin
            result_bits = (neg ? DBL_SIGN_BIT : 64'd0) | {1'b0, exponent, frac_wide[51:0]};
        end
    end

endmodule
